// ----- hdl/sebt_pkg.sv -----
// Shared types, constants and helper functions of the seasonal baseline tracker.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package sebt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int HOUR_SLOTS  = 24;
    localparam int DAY_SLOTS   = 7;
    localparam int WEEK_SLOTS  = 53;
    localparam int HOUR_AW     = 5;
    localparam int DAY_AW      = 3;
    localparam int WEEK_AW     = 6;
    localparam int SEEN_W      = 4;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 4'd10;
    localparam logic [16:0] RATE_ONE = 17'd65536;

    // Slot word: mean, spread, count.
    localparam int WORD_W = 2 * VALUE_WIDTH + SEEN_W;

    // Shared multiplier and accumulator sizes.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 84;
    localparam int RAD_W  = 68;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SQ_STEPS = ROOT_W;

    localparam logic [1:0] TBL_HOUR = 2'd0;
    localparam logic [1:0] TBL_DAY  = 2'd1;
    localparam logic [1:0] TBL_WEEK = 2'd2;
    localparam logic [1:0] TBL_NONE = 2'd3;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_BAD_CTX = 2'd2;

    localparam logic [1:0] CFG_SENSITIVITY   = 2'd0;
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd1;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CAPTURE = 4'd1;
    localparam logic [3:0] OP_READ    = 4'd2;
    localparam logic [3:0] OP_LOAD    = 4'd3;
    localparam logic [3:0] OP_STEP    = 4'd4;
    localparam logic [3:0] OP_SS      = 4'd5;
    localparam logic [3:0] OP_SB0     = 4'd6;
    localparam logic [3:0] OP_SB1     = 4'd7;
    localparam logic [3:0] OP_MM      = 4'd8;
    localparam logic [3:0] OP_MA0     = 4'd9;
    localparam logic [3:0] OP_MA1     = 4'd10;
    localparam logic [3:0] OP_SQINIT  = 4'd11;
    localparam logic [3:0] OP_SQ      = 4'd12;
    localparam logic [3:0] OP_WRITE   = 4'd13;
    localparam logic [3:0] OP_QOUT    = 4'd14;

    typedef struct packed {
        logic        command;
        logic [31:0] sample_value;
        logic [4:0]  hour_of_day;
        logic [2:0]  day_of_week;
        logic [5:0]  week_of_year;
        logic [1:0]  context_req;
    } in_item_t;

    typedef struct packed {
        logic [31:0] mean_out;
        logic [31:0] deviation_out;
        logic [31:0] threshold;
        logic [16:0] confidence;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] tbl;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] key_ok;
        logic       is_query;
        logic [1:0] ctx;
        logic       sq_done;
        logic       out_busy;
    } dp_status_t;

    // Count over ten in Q1.16, rounded to nearest.
    function automatic logic [16:0] confidence_of(input logic [SEEN_W-1:0] seen);
        logic [16:0] c;
        unique case (seen)
            4'd0:    c = 17'd0;
            4'd1:    c = 17'd6554;
            4'd2:    c = 17'd13107;
            4'd3:    c = 17'd19661;
            4'd4:    c = 17'd26214;
            4'd5:    c = 17'd32768;
            4'd6:    c = 17'd39322;
            4'd7:    c = 17'd45875;
            4'd8:    c = 17'd52429;
            4'd9:    c = 17'd58982;
            default: c = 17'd65536;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/seasonal_ewma_baseline_tracker_core.sv -----
// Observe: each table whose key is in range is updated in turn (read, load, seven multiply
// steps on one shared 34x34 multiplier, root setup, a bit-serial square root, write),
// after capture and dispatch. Query: capture, dispatch, slot read (skipped for an invalid
// context) and the result register write, plus any wait for a pending result to be taken;
// the input is freed while the result waits. Synchronous active-low reset
// restores the register defaults and marks every slot unwritten at once.
`timescale 1ns / 1ps

module seasonal_ewma_baseline_tracker_core
    import sebt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    sebt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sebt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- hdl/sebt_ctrl.sv -----
// Sequencing state machine of the seasonal baseline tracker.
// Issues datapath commands from sebt_pkg and reacts to datapath status.
`timescale 1ns / 1ps

module sebt_ctrl
    import sebt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_STEP   = 4'd4;
    localparam logic [3:0] S_SS     = 4'd5;
    localparam logic [3:0] S_SB0    = 4'd6;
    localparam logic [3:0] S_SB1    = 4'd7;
    localparam logic [3:0] S_MM     = 4'd8;
    localparam logic [3:0] S_MA0    = 4'd9;
    localparam logic [3:0] S_MA1    = 4'd10;
    localparam logic [3:0] S_SQINIT = 4'd11;
    localparam logic [3:0] S_SQ     = 4'd12;
    localparam logic [3:0] S_WRITE  = 4'd13;
    localparam logic [3:0] S_QREAD  = 4'd14;
    localparam logic [3:0] S_QOUT   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] tbl_reg, tbl_next;

    // First table at or after t whose key is in range, or none.
    function automatic logic [1:0] next_tbl(input logic [1:0] t, input logic [2:0] ok);
        logic [1:0] r;
        r = TBL_NONE;
        if (t <= TBL_WEEK && ok[2]) r = TBL_WEEK;
        if (t <= TBL_DAY  && ok[1]) r = TBL_DAY;
        if (t == TBL_HOUR && ok[0]) r = TBL_HOUR;
        return r;
    endfunction

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        tbl_next   = tbl_reg;
        cmd.op     = OP_NONE;
        cmd.tbl    = tbl_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (sts.is_query) begin
                    tbl_next   = sts.ctx;
                    state_next = (sts.ctx == TBL_NONE) ? S_QOUT : S_QREAD;
                end else begin
                    tbl_next   = next_tbl(TBL_HOUR, sts.key_ok);
                    state_next = (next_tbl(TBL_HOUR, sts.key_ok) == TBL_NONE) ? S_IDLE : S_READ;
                end
            end
            S_READ:   begin cmd.op = OP_READ;   state_next = S_LOAD;   end
            S_LOAD:   begin cmd.op = OP_LOAD;   state_next = S_STEP;   end
            S_STEP:   begin cmd.op = OP_STEP;   state_next = S_SS;     end
            S_SS:     begin cmd.op = OP_SS;     state_next = S_SB0;    end
            S_SB0:    begin cmd.op = OP_SB0;    state_next = S_SB1;    end
            S_SB1:    begin cmd.op = OP_SB1;    state_next = S_MM;     end
            S_MM:     begin cmd.op = OP_MM;     state_next = S_MA0;    end
            S_MA0:    begin cmd.op = OP_MA0;    state_next = S_MA1;    end
            S_MA1:    begin cmd.op = OP_MA1;    state_next = S_SQINIT; end
            S_SQINIT: begin cmd.op = OP_SQINIT; state_next = S_SQ;     end
            S_SQ: begin
                cmd.op = OP_SQ;
                if (sts.sq_done) state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.op = OP_WRITE;
                if (tbl_reg == TBL_WEEK) begin
                    state_next = S_IDLE;
                end else begin
                    tbl_next   = next_tbl(tbl_reg + 2'd1, sts.key_ok);
                    state_next = (next_tbl(tbl_reg + 2'd1, sts.key_ok) == TBL_NONE)
                                 ? S_IDLE : S_READ;
                end
            end
            S_QREAD: begin cmd.op = OP_READ; state_next = S_QOUT; end
            S_QOUT: begin
                // The result register must be free before a new request lands in it.
                if (!sts.out_busy) begin
                    cmd.op     = OP_QOUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tbl_reg   <= TBL_HOUR;
        end else begin
            state_reg <= state_next;
            tbl_reg   <= tbl_next;
        end
    end

endmodule

// ----- hdl/sebt_dp.sv -----
// Datapath of the seasonal baseline tracker: slot memories, shared multiplier,
// accumulator, bit-serial square root and result register. Uses sebt_pkg.
`timescale 1ns / 1ps

module sebt_dp
    import sebt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    input  in_item_t    s_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [WORD_W-1:0] hour_mem_reg [HOUR_SLOTS];
    logic [WORD_W-1:0] day_mem_reg  [DAY_SLOTS];
    logic [WORD_W-1:0] week_mem_reg [WEEK_SLOTS];
    logic [HOUR_SLOTS-1:0] hour_vld_reg;
    logic [DAY_SLOTS-1:0]  day_vld_reg;
    logic [WEEK_SLOTS-1:0] week_vld_reg;

    logic [15:0] sens_reg;
    logic [16:0] rate_reg;
    in_item_t    item_reg;

    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_ok_reg;

    logic signed [31:0] mean_reg;
    logic [31:0]        spread_reg;
    logic [SEEN_W-1:0]  seen_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [31:0]        new_mean_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [ROOT_W+1:0]  rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [5:0]         sq_cnt_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic [2:0]         key_ok;
    logic [HOUR_AW-1:0] hour_addr;
    logic [DAY_AW-1:0]  day_addr;
    logic [WEEK_AW-1:0] week_addr;
    logic [16:0]        rate_a;
    logic [16:0]        rate_b;
    logic [MUL_W-1:0]   mul_x, mul_y;
    logic [PROD_W-1:0]  mul_p;

    logic signed [31:0] ld_mean;
    logic [31:0]        ld_spread;
    logic [SEEN_W-1:0]  ld_seen;
    logic signed [32:0] diff;
    logic [33:0]        step;
    logic [32:0]        stepped;
    logic [ROOT_W+1:0]  sq_rem;
    logic [ROOT_W+1:0]  sq_trial;

    logic [47:0]        thr_prod;
    logic [39:0]        thr_add;
    logic signed [41:0] thr_sum;
    logic [31:0]        thr_sat;
    out_item_t          q_res;

    assign key_ok[0] = item_reg.hour_of_day < HOUR_SLOTS;
    assign key_ok[1] = item_reg.day_of_week < DAY_SLOTS;
    assign key_ok[2] = item_reg.week_of_year < WEEK_SLOTS;

    assign hour_addr = key_ok[0] ? item_reg.hour_of_day  : '0;
    assign day_addr  = key_ok[1] ? item_reg.day_of_week  : '0;
    assign week_addr = key_ok[2] ? item_reg.week_of_year : '0;

    assign rate_a = (rate_reg > RATE_ONE) ? RATE_ONE : rate_reg;
    assign rate_b = RATE_ONE - rate_a;

    assign sts.key_ok   = key_ok;
    assign sts.is_query = (item_reg.command == CMD_QUERY);
    assign sts.ctx      = item_reg.context_req;
    assign sts.sq_done  = (sq_cnt_reg == 6'(SQ_STEPS - 1));
    assign sts.out_busy = m_valid_reg && !m_ready;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Slot word as read, with an unwritten slot reading as all zero.
    assign ld_mean   = rd_ok_reg ? rd_word_reg[WORD_W-1 -: 32] : '0;
    assign ld_spread = rd_ok_reg ? rd_word_reg[SEEN_W +: 32]   : '0;
    assign ld_seen   = rd_ok_reg ? rd_word_reg[SEEN_W-1:0]     : '0;
    assign diff = {item_reg.sample_value[31], item_reg.sample_value} - {ld_mean[31], ld_mean};

    // One shared multiplier, its operands chosen by the current operation.
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (cmd.op)
            OP_STEP: begin mul_x = {1'b0, mag_reg};      mul_y = MUL_W'(rate_a); end
            OP_SS:   begin mul_x = MUL_W'(spread_reg);   mul_y = MUL_W'(spread_reg); end
            OP_SB0:  begin mul_x = p_reg[MUL_W-1:0];     mul_y = MUL_W'(rate_b); end
            OP_SB1:  begin mul_x = p_reg[PROD_W-1:MUL_W]; mul_y = MUL_W'(rate_b); end
            OP_MM:   begin mul_x = {1'b0, mag_reg};      mul_y = {1'b0, mag_reg}; end
            OP_MA0:  begin mul_x = p_reg[MUL_W-1:0];     mul_y = MUL_W'(rate_a); end
            OP_MA1:  begin mul_x = p_reg[PROD_W-1:MUL_W]; mul_y = MUL_W'(rate_a); end
            default: begin mul_x = '0;                   mul_y = '0; end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // Mean step: rate times error, rounded half up on the magnitude.
    assign step    = 34'((mul_p[49:0] + 50'd32768) >> FRAC_BITS);
    assign stepped = neg_reg ? ({mean_reg[31], mean_reg} - step[32:0])
                             : ({mean_reg[31], mean_reg} + step[32:0]);

    // One digit of the restoring square root per cycle.
    assign sq_rem   = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};

    assign thr_prod = sens_reg * ld_spread;
    assign thr_add  = 40'((thr_prod + 48'd128) >> 8);
    assign thr_sum  = 42'(signed'({{10{ld_mean[31]}}, ld_mean})) + 42'(signed'({2'b00, thr_add}));

    always_comb begin
        if (thr_sum > 42'sh7FFFFFFF) begin
            thr_sat = 32'h7FFFFFFF;
        end else if (thr_sum < -42'sh80000000) begin
            thr_sat = 32'h80000000;
        end else begin
            thr_sat = thr_sum[31:0];
        end
    end

    always_comb begin
        q_res = '0;
        if (item_reg.context_req == TBL_NONE) begin
            q_res.status = ST_BAD_CTX;
        end else if (ld_seen == '0) begin
            q_res.status = ST_ABSENT;
        end else begin
            q_res.mean_out      = ld_mean;
            q_res.deviation_out = ld_spread;
            q_res.threshold     = thr_sat;
            q_res.confidence    = confidence_of(ld_seen);
            q_res.status        = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg     <= 16'd768;
            rate_reg     <= 17'd6554;
            hour_vld_reg <= '0;
            day_vld_reg  <= '0;
            week_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
            sq_cnt_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_SENSITIVITY)   sens_reg <= cfg_data[15:0];
                if (cfg_index == CFG_LEARNING_RATE) rate_reg <= cfg_data;
            end
            if (cmd.op == OP_QOUT)           m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cmd.op == OP_SQINIT)    sq_cnt_reg <= '0;
            if (cmd.op == OP_SQ)        sq_cnt_reg <= sq_cnt_reg + 6'd1;
            if (cmd.op == OP_WRITE) begin
                unique case (cmd.tbl)
                    TBL_HOUR: hour_vld_reg[hour_addr] <= 1'b1;
                    TBL_DAY:  day_vld_reg[day_addr]   <= 1'b1;
                    TBL_WEEK: week_vld_reg[week_addr] <= 1'b1;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_CAPTURE: item_reg <= s_data;
            OP_READ: begin
                unique case (cmd.tbl)
                    TBL_HOUR: begin
                        rd_word_reg <= hour_mem_reg[hour_addr];
                        rd_ok_reg   <= key_ok[0] && hour_vld_reg[hour_addr];
                    end
                    TBL_DAY: begin
                        rd_word_reg <= day_mem_reg[day_addr];
                        rd_ok_reg   <= key_ok[1] && day_vld_reg[day_addr];
                    end
                    TBL_WEEK: begin
                        rd_word_reg <= week_mem_reg[week_addr];
                        rd_ok_reg   <= key_ok[2] && week_vld_reg[week_addr];
                    end
                    default: rd_ok_reg <= 1'b0;
                endcase
            end
            OP_LOAD: begin
                mean_reg   <= ld_mean;
                spread_reg <= ld_spread;
                seen_reg   <= ld_seen;
                neg_reg    <= diff[32];
                mag_reg    <= diff[32] ? 33'(-diff) : 33'(diff);
            end
            OP_STEP:  new_mean_reg <= stepped[31:0];
            OP_SS:    p_reg <= mul_p;
            OP_SB0:   acc_reg <= ACC_W'(mul_p);
            OP_SB1:   acc_reg <= acc_reg + (ACC_W'(mul_p) << MUL_W);
            OP_MM:    p_reg <= mul_p;
            OP_MA0:   acc_reg <= acc_reg + ACC_W'(mul_p);
            OP_MA1:   acc_reg <= acc_reg + (ACC_W'(mul_p) << MUL_W);
            OP_SQINIT: begin
                rad_reg  <= acc_reg[ACC_W-1:FRAC_BITS];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQ: begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (sq_rem >= sq_trial) begin
                    rem_reg  <= sq_rem - sq_trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= sq_rem;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_WRITE: begin
                unique case (cmd.tbl)
                    TBL_HOUR: hour_mem_reg[hour_addr] <= {new_mean_reg, root_reg[31:0],
                        (seen_reg < SEEN_MAX) ? seen_reg + 4'd1 : seen_reg};
                    TBL_DAY:  day_mem_reg[day_addr]   <= {new_mean_reg, root_reg[31:0],
                        (seen_reg < SEEN_MAX) ? seen_reg + 4'd1 : seen_reg};
                    TBL_WEEK: week_mem_reg[week_addr] <= {new_mean_reg, root_reg[31:0],
                        (seen_reg < SEEN_MAX) ? seen_reg + 4'd1 : seen_reg};
                    default:  ;
                endcase
            end
            OP_QOUT: m_data_reg <= q_res;
            default: ;
        endcase
    end

endmodule
